@@ hdl/bthalloc_pkg.sv @@
// ----------------------------------------------------------------------------
// bthalloc_pkg
// Shared types, constants and helpers of the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package bthalloc_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int MIN_BLOCK    = 32;
  localparam int HEADER_BYTES = 16;
  localparam int FOOTER_BYTES = 8;
  localparam int OVERHEAD     = HEADER_BYTES + FOOTER_BYTES;
  localparam int MAX_FREE_DEF = 128;

  localparam int AW    = $clog2(POOL_BYTES);  // byte address
  localparam int LW    = AW;                  // data length
  localparam int TW    = LW + 1;              // tag: length and busy flag
  localparam int WW    = AW + 2;              // address sums
  localparam int KW    = 13;                  // request length / list key
  localparam int CFG_W = 13;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_TAKE   = 3'd2;
  localparam logic [2:0] OP_DROP   = 3'd3;
  localparam logic [2:0] OP_INSERT = 3'd4;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] addr;
    logic [LW-1:0] len;
  } list_entry_t;

  typedef struct packed {
    logic [2:0]    op;
    logic [AW-1:0] addr;
    logic [KW-1:0] len;
  } list_cmd_t;

  typedef struct packed {
    logic          fit;
    logic [AW-1:0] fit_addr;
    logic [LW-1:0] fit_len;
    logic          hit;
  } list_stat_t;

  function automatic logic [TW-1:0] mk_tag(input logic [LW-1:0] len, input logic busy);
    return {len, busy};
  endfunction

endpackage

@@ hdl/bthalloc_ram.sv @@
// ----------------------------------------------------------------------------
// bthalloc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bthalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bthalloc_cell.sv @@
// ----------------------------------------------------------------------------
// bthalloc_cell
// One slot of the size-ordered free list; shifts with its neighbors.
// ----------------------------------------------------------------------------
module bthalloc_cell
  import bthalloc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head,
  input  list_cmd_t   cmd,
  input  list_entry_t prev_e,
  input  list_entry_t next_e,
  input  logic        prev_pos,
  input  logic        drop_sel,
  output list_entry_t e,
  output logic        ge,
  output logic        pos,
  output logic        hit
);

  list_entry_t e_r, e_nxt, new_e;

  assign ge  = e_r.valid && ({1'b0, e_r.len} >= cmd.len);
  assign pos = !e_r.valid || ({1'b0, e_r.len} >= cmd.len);
  assign hit = e_r.valid && (e_r.addr == cmd.addr);
  assign e   = e_r;

  always_comb begin
    new_e.valid = 1'b1;
    new_e.addr  = cmd.addr;
    new_e.len   = cmd.len[LW-1:0];
    e_nxt = e_r;
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        e_nxt = new_e;
        e_nxt.valid = head;
      end
      OP_TAKE: begin
        if (ge) e_nxt = next_e;
      end
      OP_DROP: begin
        if (drop_sel) e_nxt = next_e;
      end
      OP_INSERT: begin
        if (prev_pos) e_nxt = prev_e;
        else if (pos) e_nxt = new_e;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.valid <= 1'b0;
    end else begin
      e_r <= e_nxt;
    end
  end

endmodule

@@ hdl/bthalloc_list.sv @@
// ----------------------------------------------------------------------------
// bthalloc_list
// Chain of list cells holding free blocks sorted by ascending length.
// ----------------------------------------------------------------------------
module bthalloc_list
  import bthalloc_pkg::*;
#(
  parameter int N = MAX_FREE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  list_cmd_t  cmd,
  output list_stat_t stat
);

  localparam int LV = $clog2(N);

  list_entry_t ent [N];
  logic [N-1:0] ge, pos, hit, first;
  logic [N-1:0] pre [LV+1];
  list_entry_t  empty_e;

  assign empty_e = '0;
  assign pre[0]  = hit;

  genvar l, j;
  generate
    for (l = 0; l < LV; l++) begin : g_lvl
      for (j = 0; j < N; j++) begin : g_bit
        if (j >= (1 << l)) begin : g_or
          assign pre[l+1][j] = pre[l][j] | pre[l][j-(1<<l)];
        end else begin : g_pass
          assign pre[l+1][j] = pre[l][j];
        end
      end
    end

    for (j = 0; j < N; j++) begin : g_cell
      if (j == 0) begin : g_head
        assign first[j] = ge[j];
        bthalloc_cell u_cell (
          .clk(clk), .rst_n(rst_n), .head(1'b1), .cmd(cmd),
          .prev_e(empty_e), .next_e(ent[j+1]), .prev_pos(1'b0),
          .drop_sel(pre[LV][j]), .e(ent[j]), .ge(ge[j]), .pos(pos[j]), .hit(hit[j])
        );
      end else if (j == N-1) begin : g_tail
        assign first[j] = ge[j] & ~ge[j-1];
        bthalloc_cell u_cell (
          .clk(clk), .rst_n(rst_n), .head(1'b0), .cmd(cmd),
          .prev_e(ent[j-1]), .next_e(empty_e), .prev_pos(pos[j-1]),
          .drop_sel(pre[LV][j]), .e(ent[j]), .ge(ge[j]), .pos(pos[j]), .hit(hit[j])
        );
      end else begin : g_mid
        assign first[j] = ge[j] & ~ge[j-1];
        bthalloc_cell u_cell (
          .clk(clk), .rst_n(rst_n), .head(1'b0), .cmd(cmd),
          .prev_e(ent[j-1]), .next_e(ent[j+1]), .prev_pos(pos[j-1]),
          .drop_sel(pre[LV][j]), .e(ent[j]), .ge(ge[j]), .pos(pos[j]), .hit(hit[j])
        );
      end
    end
  endgenerate

  always_comb begin
    stat.fit      = |ge;
    stat.hit      = |hit;
    stat.fit_addr = '0;
    stat.fit_len  = '0;
    for (int k = 0; k < N; k++) begin
      if (first[k]) begin
        stat.fit_addr = stat.fit_addr | ent[k].addr;
        stat.fit_len  = stat.fit_len | ent[k].len;
      end
    end
  end

endmodule

@@ hdl/boundary_tag_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// Best-fit byte pool allocator with boundary tags and a size-sorted free list.
// ----------------------------------------------------------------------------
// in_ready returns with out_valid. One request at a time; the tag RAM read
// port paces the free sequence. Reset and every config write run a clearing
// pass over every address of the tag RAMs during which no request is taken.
module boundary_tag_heap_allocator
  import bthalloc_pkg::*;
#(
  parameter int MAX_FREE_BLOCKS = MAX_FREE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_kind,
  input  logic [KW-1:0]    in_request_bytes,
  input  logic [AW-1:0]    in_block_address,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [AW-1:0]    out_data_address,
  output logic             out_status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_pool_bytes
);

  localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FIND  = 4'd2;
  localparam logic [3:0] S_AL1   = 4'd3;
  localparam logic [3:0] S_AL2   = 4'd4;
  localparam logic [3:0] S_F0    = 4'd5;
  localparam logic [3:0] S_F1    = 4'd6;
  localparam logic [3:0] S_F2    = 4'd7;
  localparam logic [3:0] S_F3    = 4'd8;
  localparam logic [3:0] S_F4    = 4'd9;
  localparam logic [3:0] S_F5    = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic             respond_r, respond_nxt;
  logic [CFG_W-1:0] live_r, live_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [AW-1:0]    out_addr_r, out_addr_nxt;
  logic             out_status_r, out_status_nxt;

  logic [1:0]       kind_r, kind_nxt;
  logic [KW-1:0]    req_r, req_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    b_r, b_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [AW-1:0]    start_r, start_nxt;
  logic [LW-1:0]    total_r, total_nxt;
  logic [LW-1:0]    plen_r, plen_nxt;
  logic [AW-1:0]    pb_r, pb_nxt;
  logic             prev_ok_r, prev_ok_nxt;
  logic [AW-1:0]    nb_r, nb_nxt;
  logic             nb_in_r, nb_in_nxt;
  logic [AW-1:0]    res_addr_r, res_addr_nxt;
  logic             res_status_r, res_status_nxt;

  logic          h_we, f_we;
  logic [AW-1:0] h_wa, h_ra, f_wa, f_ra;
  logic [TW-1:0] h_wd, h_rd, f_wd, f_rd;

  list_cmd_t  cmd;
  list_stat_t stat;

  logic [LW-1:0] clr_len, hl, pl, nl, rl;
  logic [WW-1:0] fw, sw, nbw;
  logic [AW-1:0] bf;
  logic          split;

  bthalloc_ram #(.WIDTH(TW), .DEPTH(POOL_BYTES)) u_hdr_ram (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  bthalloc_ram #(.WIDTH(TW), .DEPTH(POOL_BYTES)) u_ftr_ram (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );

  bthalloc_list #(.N(MAX_FREE_BLOCKS)) u_list (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_data_address = out_addr_r;
  assign out_status       = out_status_r;

  assign clr_len = LW'(live_r - CFG_W'(OVERHEAD));
  assign hl      = h_rd[TW-1:1];
  assign pl      = f_rd[TW-1:1];
  assign nl      = h_rd[TW-1:1];
  assign rl      = LW'(WW'(len_r) - WW'(req_r) - WW'(OVERHEAD));
  assign bf      = addr_r - AW'(HEADER_BYTES);
  assign split   = (WW'(len_r) >= WW'(req_r) + WW'(MIN_BLOCK)) &&
                   (WW'(len_r) >= WW'(req_r) + WW'(OVERHEAD));
  assign nbw     = WW'(b_r) + WW'(len_r) + WW'(OVERHEAD);

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    respond_nxt    = respond_r;
    live_nxt       = live_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    kind_nxt       = kind_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    b_nxt          = b_r;
    len_nxt        = len_r;
    start_nxt      = start_r;
    total_nxt      = total_r;
    plen_nxt       = plen_r;
    pb_nxt         = pb_r;
    prev_ok_nxt    = prev_ok_r;
    nb_nxt         = nb_r;
    nb_in_nxt      = nb_in_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    h_we = 1'b0;
    h_wa = '0;
    h_wd = '0;
    h_ra = '0;
    f_we = 1'b0;
    f_wa = '0;
    f_wd = '0;
    f_ra = '0;
    cmd  = '{op: OP_NOP, addr: '0, len: '0};
    fw   = '0;
    sw   = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_SWEEP: begin
        cmd     = '{op: OP_LOAD, addr: '0, len: KW'(clr_len)};
        cnt_nxt = CW'(1);
        h_we = 1'b1;
        h_wa = sweep_r;
        h_wd = (sweep_r == '0) ? mk_tag(clr_len, 1'b0) : '0;
        f_we = 1'b1;
        f_wa = sweep_r;
        f_wd = (WW'(sweep_r) == WW'(live_r) - WW'(FOOTER_BYTES)) ?
               mk_tag(clr_len, 1'b0) : '0;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == '1) state_nxt = respond_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt       = in_kind;
          req_nxt        = in_request_bytes;
          addr_nxt       = in_block_address;
          res_addr_nxt   = '0;
          res_status_nxt = 1'b0;
          unique case (in_kind)
            KIND_ALLOC, KIND_REALLOC: state_nxt = S_FIND;
            KIND_FREE:                state_nxt = S_F0;
            default: begin
              state_nxt   = S_SWEEP;
              sweep_nxt   = '0;
              respond_nxt = 1'b1;
            end
          endcase
        end
      end
      S_FIND: begin
        cmd = '{op: OP_TAKE, addr: '0, len: req_r};
        if (stat.fit) begin
          b_nxt     = stat.fit_addr;
          len_nxt   = stat.fit_len;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_AL1;
        end else begin
          res_status_nxt = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_AL1: begin
        h_we = 1'b1;
        h_wa = b_r;
        if (split) begin
          h_wd = mk_tag(req_r[LW-1:0], 1'b1);
          fw   = WW'(b_r) + WW'(HEADER_BYTES) + WW'(req_r);
          f_wd = mk_tag(req_r[LW-1:0], 1'b1);
          state_nxt = S_AL2;
        end else begin
          h_wd = mk_tag(len_r, 1'b1);
          fw   = WW'(b_r) + WW'(HEADER_BYTES) + WW'(len_r);
          f_wd = mk_tag(len_r, 1'b1);
          res_addr_nxt = b_r + AW'(HEADER_BYTES);
          state_nxt    = (kind_r == KIND_REALLOC) ? S_F0 : S_DONE;
        end
        f_we = (fw < WW'(POOL_BYTES));
        f_wa = fw[AW-1:0];
      end
      S_AL2: begin
        sw   = WW'(b_r) + WW'(req_r) + WW'(OVERHEAD);
        h_we = 1'b1;
        h_wa = sw[AW-1:0];
        h_wd = mk_tag(rl, 1'b0);
        fw   = WW'(b_r) + WW'(HEADER_BYTES) + WW'(len_r);
        f_we = (fw < WW'(POOL_BYTES));
        f_wa = fw[AW-1:0];
        f_wd = mk_tag(rl, 1'b0);
        if (cnt_r < CW'(MAX_FREE_BLOCKS)) begin
          cmd     = '{op: OP_INSERT, addr: sw[AW-1:0], len: KW'(rl)};
          cnt_nxt = cnt_r + CW'(1);
        end
        res_addr_nxt = b_r + AW'(HEADER_BYTES);
        state_nxt    = (kind_r == KIND_REALLOC) ? S_F0 : S_DONE;
      end
      S_F0: begin
        h_ra = bf;
        b_nxt = bf;
        if (addr_r < AW'(HEADER_BYTES) || WW'(bf) >= WW'(live_r)) state_nxt = S_DONE;
        else state_nxt = S_F1;
      end
      S_F1: begin
        f_ra = b_r - AW'(FOOTER_BYTES);
        if (!h_rd[0] || (WW'(b_r) + WW'(hl) + WW'(OVERHEAD) > WW'(live_r))) begin
          state_nxt = S_DONE;
        end else begin
          h_we = 1'b1;
          h_wa = b_r;
          h_wd = mk_tag(hl, 1'b0);
          fw   = WW'(b_r) + WW'(HEADER_BYTES) + WW'(hl);
          f_we = (fw < WW'(POOL_BYTES));
          f_wa = fw[AW-1:0];
          f_wd = mk_tag(hl, 1'b0);
          start_nxt = b_r;
          total_nxt = hl;
          len_nxt   = hl;
          state_nxt = S_F2;
        end
      end
      S_F2: begin
        sw   = WW'(b_r) - WW'(pl) - WW'(OVERHEAD);
        h_ra = sw[AW-1:0];
        pb_nxt      = sw[AW-1:0];
        plen_nxt    = pl;
        prev_ok_nxt = (b_r >= AW'(FOOTER_BYTES)) && !f_rd[0] &&
                      (WW'(b_r) >= WW'(pl) + WW'(OVERHEAD));
        state_nxt   = S_F3;
      end
      S_F3: begin
        if (prev_ok_r && h_rd == mk_tag(plen_r, 1'b0)) begin
          cmd = '{op: OP_DROP, addr: pb_r, len: '0};
          if (stat.hit) cnt_nxt = cnt_r - CW'(1);
          start_nxt = pb_r;
          total_nxt = LW'(WW'(total_r) + WW'(plen_r) + WW'(OVERHEAD));
        end
        h_ra      = nbw[AW-1:0];
        nb_nxt    = nbw[AW-1:0];
        nb_in_nxt = (nbw < WW'(live_r));
        state_nxt = S_F4;
      end
      S_F4: begin
        if (nb_in_r && !h_rd[0] &&
            (WW'(nb_r) + WW'(nl) + WW'(OVERHEAD) <= WW'(live_r))) begin
          cmd = '{op: OP_DROP, addr: nb_r, len: '0};
          if (stat.hit) cnt_nxt = cnt_r - CW'(1);
          total_nxt = LW'(WW'(total_r) + WW'(nl) + WW'(OVERHEAD));
        end
        state_nxt = S_F5;
      end
      S_F5: begin
        h_we = 1'b1;
        h_wa = start_r;
        h_wd = mk_tag(total_r, 1'b0);
        fw   = WW'(start_r) + WW'(HEADER_BYTES) + WW'(total_r);
        f_we = (fw < WW'(POOL_BYTES));
        f_wa = fw[AW-1:0];
        f_wd = mk_tag(total_r, 1'b0);
        if (cnt_r < CW'(MAX_FREE_BLOCKS)) begin
          cmd     = '{op: OP_INSERT, addr: start_r, len: KW'(total_r)};
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      if (cfg_pool_bytes < CFG_W'(OVERHEAD + MIN_BLOCK)) live_nxt = CFG_W'(OVERHEAD + MIN_BLOCK);
      else if (cfg_pool_bytes > CFG_W'(POOL_BYTES)) live_nxt = CFG_W'(POOL_BYTES);
      else live_nxt = cfg_pool_bytes;
      state_nxt   = S_SWEEP;
      sweep_nxt   = '0;
      respond_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      respond_r   <= 1'b0;
      live_r      <= CFG_W'(POOL_BYTES);
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      respond_r   <= respond_nxt;
      live_r      <= live_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    b_r          <= b_nxt;
    len_r        <= len_nxt;
    start_r      <= start_nxt;
    total_r      <= total_nxt;
    plen_r       <= plen_nxt;
    pb_r         <= pb_nxt;
    prev_ok_r    <= prev_ok_nxt;
    nb_r         <= nb_nxt;
    nb_in_r      <= nb_in_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule

@@ verif/boundary_tag_heap_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_checker
// Watches the request, result and config channels of the allocator, keeps its
// own boundary-tag pool and size-sorted free list, predicts the grant of every
// accepted request and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_checker
  import bthalloc_pkg::*;
#(
  parameter int MAX_FREE_BLOCKS = MAX_FREE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_kind,
  input  logic [KW-1:0]    in_request_bytes,
  input  logic [AW-1:0]    in_block_address,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [AW-1:0]    out_data_address,
  input  logic             out_status,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_pool_bytes,
  output int               fail_count
);

  typedef struct {
    logic [AW-1:0] addr;
    logic          status;
  } grant_t;

  bit [TW-1:0]  hdr_tag[POOL_BYTES];
  bit [TW-1:0]  ftr_tag[POOL_BYTES];
  int unsigned  avail_q[$];
  int unsigned  pool_setting;
  int unsigned  live_pool;
  grant_t       grant_q[$];
  int           mismatches;

  function automatic int unsigned tag_len(int unsigned b);
    return (b < POOL_BYTES) ? int'(hdr_tag[b][TW-1:1]) : 0;
  endfunction

  function automatic void put_block(int unsigned b, int unsigned len, bit busy);
    int unsigned f;
    f = b + HEADER_BYTES + len;
    if (b < POOL_BYTES) hdr_tag[b] = {len[LW-1:0], busy};
    if (f < POOL_BYTES) ftr_tag[f] = {len[LW-1:0], busy};
  endfunction

  function automatic void rebuild_pool();
    int unsigned p;
    p = pool_setting;
    if (p < OVERHEAD + MIN_BLOCK) p = OVERHEAD + MIN_BLOCK;
    if (p > POOL_BYTES) p = POOL_BYTES;
    live_pool = p;
    foreach (hdr_tag[i]) begin
      hdr_tag[i] = '0;
      ftr_tag[i] = '0;
    end
    put_block(0, p - OVERHEAD, 1'b0);
    avail_q = {};
    avail_q.push_back(0);
  endfunction

  function automatic void list_drop(int unsigned b);
    foreach (avail_q[i]) begin
      if (avail_q[i] == b) begin
        avail_q.delete(i);
        return;
      end
    end
  endfunction

  function automatic void list_add(int unsigned b);
    int i;
    i = 0;
    if (avail_q.size() >= MAX_FREE_BLOCKS) return;
    while (i < avail_q.size() && tag_len(avail_q[i]) < tag_len(b)) i++;
    avail_q.insert(i, b);
  endfunction

  function automatic bit try_grant(int unsigned n, output int unsigned a);
    int i;
    int unsigned b, len, r;
    i = 0;
    a = 0;
    while (i < avail_q.size() && tag_len(avail_q[i]) < n) i++;
    if (i >= avail_q.size()) return 1'b0;
    b = avail_q[i];
    len = tag_len(b);
    avail_q.delete(i);
    if (len >= n + MIN_BLOCK && len >= n + OVERHEAD) begin
      r = b + n + OVERHEAD;
      put_block(b, n, 1'b1);
      put_block(r, len - n - OVERHEAD, 1'b0);
      list_add(r);
    end else begin
      put_block(b, len, 1'b1);
    end
    a = b + HEADER_BYTES;
    return 1'b1;
  endfunction

  function automatic void release_block(int unsigned a);
    int unsigned b, len, start, total, ft, plen, pb, nb, nlen;
    if (a < HEADER_BYTES) return;
    b = a - HEADER_BYTES;
    if (b >= live_pool || !hdr_tag[b][0]) return;
    len = tag_len(b);
    if (b + len + OVERHEAD > live_pool) return;
    start = b;
    total = len;
    put_block(b, len, 1'b0);
    if (b >= FOOTER_BYTES) begin
      ft = ftr_tag[b - FOOTER_BYTES];
      plen = ft >> 1;
      if (!ft[0] && b >= OVERHEAD + plen) begin
        pb = b - OVERHEAD - plen;
        if (hdr_tag[pb] == (plen << 1)) begin
          list_drop(pb);
          start = pb;
          total += plen + OVERHEAD;
        end
      end
    end
    nb = b + len + OVERHEAD;
    if (nb < live_pool && !hdr_tag[nb][0]) begin
      nlen = tag_len(nb);
      if (nb + nlen + OVERHEAD <= live_pool) begin
        list_drop(nb);
        total += nlen + OVERHEAD;
      end
    end
    put_block(start, total, 1'b0);
    list_add(start);
  endfunction

  initial begin
    pool_setting = POOL_BYTES;
    rebuild_pool();
    mismatches = 0;
  end

  always @(posedge clk) begin
    grant_t      g;
    grant_t      e;
    int unsigned a;
    if (!rst_n) begin
      pool_setting = POOL_BYTES;
      rebuild_pool();
      grant_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        pool_setting = cfg_pool_bytes;
        rebuild_pool();
      end
      if (in_valid && in_ready) begin
        g.addr = '0;
        g.status = 1'b0;
        case (in_kind)
          KIND_ALLOC, KIND_REALLOC: begin
            if (try_grant(in_request_bytes, a)) begin
              if (in_kind == KIND_REALLOC) release_block(in_block_address);
              g.addr = a[AW-1:0];
            end else begin
              g.status = 1'b1;
            end
          end
          KIND_FREE: release_block(in_block_address);
          default: rebuild_pool();
        endcase
        grant_q.push_back(g);
      end
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result beat: data_address %0d status %0d",
                 out_data_address, out_status);
          mismatches++;
        end else begin
          e = grant_q.pop_front();
          if (out_data_address !== e.addr) begin
            $error("data_address expected %0d actual %0d", e.addr, out_data_address);
            mismatches++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches + grant_q.size();
  end

endmodule

@@ verif/tb_boundary_tag_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_boundary_tag_heap_allocator
// Drives directed and random alloc, free, realloc and clear requests with
// random gaps and result stalls across several pool sizes; a checker beside
// the allocator predicts every grant and counts mismatches.
// ----------------------------------------------------------------------------
module tb_boundary_tag_heap_allocator;
  import bthalloc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 250;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       in_kind;
  logic [KW-1:0]    in_request_bytes;
  logic [AW-1:0]    in_block_address;
  logic             out_valid;
  logic             out_ready;
  logic [AW-1:0]    out_data_address;
  logic             out_status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_pool_bytes;
  int               fail_count;

  logic [1:0]    kind_q[$];
  logic [AW-1:0] live_q[$];
  int            sent;
  int            received;
  int            idle_cycles;
  bit            calm;

  boundary_tag_heap_allocator DUT (.*);

  boundary_tag_heap_allocator_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    logic [1:0] k;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (in_valid && in_ready) begin
        kind_q.push_back(in_kind);
        sent++;
      end
      if (out_valid && out_ready) begin
        k = kind_q.pop_front();
        received++;
        if (k == KIND_CLEAR) live_q.delete();
        else if ((k == KIND_ALLOC || k == KIND_REALLOC) && !out_status)
          live_q.push_back(out_data_address);
      end
    end
  end

  // result side stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_beat(logic [1:0] k, int unsigned req, int unsigned addr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_request_bytes <= req[KW-1:0];
    in_block_address <= addr[AW-1:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_pool(int unsigned bytes);
    in_valid <= 1'b0;
    while (received != sent) @(negedge clk);
    repeat (4) @(negedge clk);
    live_q.delete();
    cfg_valid      <= 1'b1;
    cfg_pool_bytes <= bytes[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beat();
    int          pick;
    int          idx;
    int unsigned req;
    int unsigned addr;
    logic [1:0]  k;
    pick = $urandom_range(0, 99);
    req = ($urandom_range(0, 19) < 14) ? $urandom_range(0, 64)
        : ($urandom_range(0, 4) != 0) ? $urandom_range(0, 600) : $urandom_range(0, 4096);
    addr = $urandom_range(0, 4095);
    if (pick < 40) k = KIND_ALLOC;
    else if (pick < 82) k = KIND_FREE;
    else if (pick < 99) k = KIND_REALLOC;
    else k = KIND_CLEAR;
    if ((k == KIND_FREE || k == KIND_REALLOC) && $urandom_range(0, 9) != 0) begin
      if (live_q.size() == 0) begin
        k = KIND_ALLOC;
      end else begin
        idx = $urandom_range(0, live_q.size() - 1);
        addr = live_q[idx];
        live_q.delete(idx);
      end
    end
    send_beat(k, req, addr);
  endtask

  initial begin
    int unsigned pools[5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_ALLOC;
    in_request_bytes = '0;
    in_block_address = '0;
    cfg_valid = 1'b0;
    cfg_pool_bytes = '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, pool at reset size
    send_beat(KIND_ALLOC, 0, 0);
    send_beat(KIND_ALLOC, 100, 0);
    send_beat(KIND_FREE, 0, 16);
    send_beat(KIND_FREE, 0, 16);
    send_beat(KIND_FREE, 0, 0);
    send_beat(KIND_FREE, 0, 4095);
    send_beat(KIND_REALLOC, 200, 40);
    send_beat(KIND_REALLOC, 8, 3000);
    send_beat(KIND_ALLOC, 4096, 0);
    send_beat(KIND_REALLOC, 4096, 16);
    send_beat(KIND_CLEAR, 0, 0);
    send_beat(KIND_ALLOC, 4072, 0);
    send_beat(KIND_ALLOC, 1, 0);
    send_beat(KIND_FREE, 0, 16);
    send_beat(KIND_ALLOC, 4040, 0);
    send_beat(KIND_FREE, 0, 16);
    send_beat(KIND_ALLOC, 4049, 0);
    send_beat(KIND_FREE, 0, 16);
    send_beat(KIND_ALLOC, 10, 0);
    send_beat(KIND_ALLOC, 10, 0);
    send_beat(KIND_ALLOC, 10, 0);
    send_beat(KIND_FREE, 0, 16);
    send_beat(KIND_FREE, 0, 84);
    send_beat(KIND_FREE, 0, 50);
    send_beat(KIND_CLEAR, 0, 0);

    pools = '{64, 4096, $urandom_range(64, 4096), 512, 4096};
    foreach (pools[p]) begin
      write_pool(pools[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        random_beat();
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (received != sent) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
